[design/cspu_pkg.sv]
// shared types, codes and helpers of the convex support point unit
// used by the datapath, controller and top of the block, depends on nothing
package cspu_pkg;

  localparam int FRAC_BITS = 16;
  localparam int VTX_DEPTH = 64;
  localparam int VTX_AW = $clog2(VTX_DEPTH);
  localparam int DOT_W = 64 - FRAC_BITS + 2;

  localparam logic [1:0] OP_QUERY = 2'd0;
  localparam logic [1:0] OP_LOAD = 2'd1;
  localparam logic [1:0] OP_SEED = 2'd2;

  localparam logic [2:0] KIND_BOX = 3'd0;
  localparam logic [2:0] KIND_SPHERE = 3'd1;
  localparam logic [2:0] KIND_CYL = 3'd2;
  localparam logic [2:0] KIND_CONE = 3'd3;
  localparam logic [2:0] KIND_POLY = 3'd4;

  localparam logic [2:0] REG_KIND = 3'd0;
  localparam logic [2:0] REG_RMAIN = 3'd1;
  localparam logic [2:0] REG_RBOT = 3'd2;
  localparam logic [2:0] REG_HH = 3'd3;
  localparam logic [2:0] REG_SLOPE = 3'd4;
  localparam logic [2:0] REG_HX = 3'd5;
  localparam logic [2:0] REG_HY = 3'd6;
  localparam logic [2:0] REG_HZ = 3'd7;

  // datapath micro operations
  localparam logic [4:0] DO_NONE = 5'd0;
  localparam logic [4:0] DO_CAPTURE = 5'd1;
  localparam logic [4:0] DO_BOX = 5'd2;
  localparam logic [4:0] DO_SQX = 5'd3;
  localparam logic [4:0] DO_SQY = 5'd4;
  localparam logic [4:0] DO_SQZ = 5'd5;
  localparam logic [4:0] DO_SQA = 5'd6;
  localparam logic [4:0] DO_PL = 5'd7;
  localparam logic [4:0] DO_LEN = 5'd8;
  localparam logic [4:0] DO_CONE_MUL = 5'd9;
  localparam logic [4:0] DO_CONE_SEL = 5'd10;
  localparam logic [4:0] DO_SMUL = 5'd11;
  localparam logic [4:0] DO_DSTART = 5'd12;
  localparam logic [4:0] DO_DWRITE = 5'd13;
  localparam logic [4:0] DO_EMPTY = 5'd14;
  localparam logic [4:0] DO_CINIT = 5'd15;
  localparam logic [4:0] DO_DMX = 5'd16;
  localparam logic [4:0] DO_DMY = 5'd17;
  localparam logic [4:0] DO_DMZ = 5'd18;
  localparam logic [4:0] DO_DACC = 5'd19;
  localparam logic [4:0] DO_FIRST = 5'd20;
  localparam logic [4:0] DO_SECOND = 5'd21;
  localparam logic [4:0] DO_STEP = 5'd22;
  localparam logic [4:0] DO_PFIN = 5'd23;
  localparam logic [4:0] DO_PLOAD = 5'd24;
  localparam logic [4:0] DO_OUT = 5'd25;

  typedef struct packed {
    logic [4:0] op;
    logic [1:0] axis;
  } cspu_cmd_t;

  typedef struct packed {
    logic [2:0] kind;
    logic       count_zero;
    logic       scale_ok;
    logic [1:0] last_axis;
    logic       sqrt_done;
    logic       div_done;
    logic       sqrt_busy;
    logic       div_busy;
    logic       climb_cont;
  } cspu_status_t;

  function automatic logic [31:0] mag32(input logic [31:0] v);
    mag32 = v[31] ? 32'(-v) : v;
  endfunction

endpackage

[design/cspu_ram.sv]
// generic single write port ram with registered read
// no dependencies
module cspu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[design/cspu_sqrt.sv]
// iterative floor square root of a 64-bit value, two bits per cycle
// no dependencies
module cspu_sqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] radicand,
  output logic        busy,
  output logic        done,
  output logic [31:0] root
);

  logic [63:0] rad;
  logic [33:0] rem;
  logic [4:0]  cnt;
  logic [33:0] rem_s;
  logic [33:0] trial;

  assign rem_s = {rem[31:0], rad[63:62]};
  assign trial = {root, 2'b01};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd31) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad <= radicand;
      rem <= '0;
      root <= '0;
      cnt <= '0;
    end else if (busy) begin
      rad <= {rad[61:0], 2'b00};
      cnt <= cnt + 5'd1;
      if (rem_s >= trial) begin
        rem <= rem_s - trial;
        root <= {root[30:0], 1'b1};
      end else begin
        rem <= rem_s;
        root <= {root[30:0], 1'b0};
      end
    end
  end

endmodule

[design/cspu_div.sv]
// restoring divider, 64-bit dividend by 32-bit divisor, one bit per cycle
// keeps the low 32 quotient bits; no dependencies
module cspu_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [63:0] dividend,
  input  logic [31:0] divisor,
  output logic        busy,
  output logic        done,
  output logic [31:0] quotient
);

  logic [63:0] dvd;
  logic [31:0] dsr;
  logic [31:0] rem;
  logic [5:0]  cnt;
  logic [32:0] rem_s;

  assign rem_s = {rem, dvd[63]};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd63) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
      dsr <= divisor;
      rem <= '0;
      quotient <= '0;
      cnt <= '0;
    end else if (busy) begin
      dvd <= {dvd[62:0], 1'b0};
      cnt <= cnt + 6'd1;
      if (rem_s >= {1'b0, dsr}) begin
        rem <= 32'(rem_s - {1'b0, dsr});
        quotient <= {quotient[30:0], 1'b1};
      end else begin
        rem <= rem_s[31:0];
        quotient <= {quotient[30:0], 1'b0};
      end
    end
  end

endmodule

[design/cspu_datapath.sv]
// datapath: config registers, shared multiplier, sqrt and divide units,
// vertex store and climb registers; depends on cspu_pkg, cspu_ram, cspu_sqrt, cspu_div
module cspu_datapath
  import cspu_pkg::*;
(
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [2:0]     cfg_index,
  input  logic [30:0]    cfg_data,
  input  logic [103:0]   s_tdata,
  input  logic [1:0]     s_tuser,
  input  logic           s_tlast,
  output logic [103:0]   m_tdata,
  output logic           m_tuser,
  input  cspu_cmd_t      cmd,
  output cspu_status_t   status
);

  logic [2:0]  shape_kind;
  logic [30:0] radius_main, radius_bottom, half_height, half_x, half_y, half_z;
  logic signed [17:0] cone_slope;

  logic [31:0] dx, dy, dz;
  logic [31:0] px, py, pz;
  logic [VTX_AW-1:0] chosen;
  logic        err;
  logic [31:0] ox, oy, oz;
  logic [VTX_AW-1:0] ochosen;
  logic        oerr;

  logic [6:0]        vertex_count;
  logic [VTX_AW-1:0] seed_index;

  logic signed [32:0] ma, mb;
  logic signed [65:0] mul_full;
  logic signed [63:0] prod;
  logic signed [63:0] prod_fl;

  logic [63:0] sqxy, sqall;
  logic [31:0] pl, len;
  logic [30:0] radius_cur;

  logic        sq_start, sq_busy, sq_done;
  logic [63:0] sq_in;
  logic [31:0] sq_root;
  logic        dv_start, dv_busy, dv_done;
  logic [31:0] dv_q, dv_dsr;

  logic [VTX_AW-1:0] cur, nxt, didx;
  logic signed [DOT_W-1:0] dp, ndp, acc;
  logic [6:0]  steps;
  logic        dir_back;
  logic        ram_we;
  logic [95:0] rdata;
  logic [VTX_AW-1:0] slot;

  logic [31:0] d_axis;
  logic [31:0] neg_hh;
  logic signed [63:0] rhs;
  logic        bottom;
  logic        gt, cont;
  logic [VTX_AW-1:0] seed_sel;

  function automatic logic [VTX_AW-1:0] vinc(input logic [VTX_AW-1:0] i,
                                             input logic [6:0] n);
    vinc = ({1'b0, i} + 7'd1 < n) ? VTX_AW'(i + 1'b1) : '0;
  endfunction

  function automatic logic [VTX_AW-1:0] vdec(input logic [VTX_AW-1:0] i,
                                             input logic [6:0] n);
    vdec = (i == '0) ? VTX_AW'(n - 7'd1) : VTX_AW'(i - 1'b1);
  endfunction

  assign slot = s_tdata[96 +: VTX_AW];
  assign neg_hh = 32'(-{1'b0, half_height});
  assign seed_sel = ({1'b0, seed_index} < vertex_count) ? seed_index : '0;

  always_comb begin
    unique case (cmd.axis)
      2'd0: d_axis = dx;
      2'd1: d_axis = dy;
      default: d_axis = dz;
    endcase
  end

  // shared multiplier operand select
  always_comb begin
    ma = '0;
    mb = '0;
    unique case (cmd.op)
      DO_SQX: begin
        ma = {1'b0, mag32(dx)};
        mb = {1'b0, mag32(dx)};
      end
      DO_SQY: begin
        ma = {1'b0, mag32(dy)};
        mb = {1'b0, mag32(dy)};
      end
      DO_SQZ: begin
        ma = {1'b0, mag32(dz)};
        mb = {1'b0, mag32(dz)};
      end
      DO_CONE_MUL: begin
        ma = {1'b0, len};
        mb = {{15{cone_slope[17]}}, cone_slope};
      end
      DO_SMUL: begin
        ma = {1'b0, mag32(d_axis)};
        mb = {2'b00, radius_cur};
      end
      DO_DMX: begin
        ma = {rdata[31], rdata[31:0]};
        mb = {dx[31], dx};
      end
      DO_DMY: begin
        ma = {rdata[63], rdata[63:32]};
        mb = {dy[31], dy};
      end
      DO_DMZ: begin
        ma = {rdata[95], rdata[95:64]};
        mb = {dz[31], dz};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  assign mul_full = ma * mb;
  assign prod_fl = prod >>> FRAC_BITS;
  assign rhs = prod >>> FRAC_BITS;
  assign bottom = $signed({{32{dz[31]}}, dz}) <= rhs + 64'sd1;

  assign gt = ndp > dp;
  assign cont = ($signed({ndp[DOT_W-1], ndp}) > $signed({dp[DOT_W-1], dp}) + 1)
                && (steps < vertex_count);

  assign sq_start = (cmd.op == DO_SQA) || (cmd.op == DO_PL);
  assign sq_in = (cmd.op == DO_SQA) ? sqxy : sqall;
  assign dv_start = (cmd.op == DO_DSTART);
  assign dv_dsr = (shape_kind == KIND_SPHERE) ? len : pl;
  assign ram_we = (cmd.op == DO_CAPTURE) && (s_tuser == OP_LOAD);

  always_ff @(posedge clk) begin
    prod <= mul_full[63:0];
  end

  // control state: config, count, seed
  always_ff @(posedge clk) begin
    if (rst) begin
      shape_kind <= '0;
      radius_main <= '0;
      radius_bottom <= '0;
      half_height <= '0;
      cone_slope <= '0;
      half_x <= '0;
      half_y <= '0;
      half_z <= '0;
      vertex_count <= '0;
      seed_index <= '0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KIND: shape_kind <= cfg_data[2:0];
          REG_RMAIN: radius_main <= cfg_data;
          REG_RBOT: radius_bottom <= cfg_data;
          REG_HH: half_height <= cfg_data;
          REG_SLOPE: cone_slope <= cfg_data[17:0];
          REG_HX: half_x <= cfg_data;
          REG_HY: half_y <= cfg_data;
          REG_HZ: half_z <= cfg_data;
          default: ;
        endcase
      end
      if (cmd.op == DO_CAPTURE && s_tuser == OP_LOAD && s_tlast) begin
        vertex_count <= {1'b0, slot} + 7'd1;
      end
      if (cmd.op == DO_CAPTURE && s_tuser == OP_SEED) begin
        seed_index <= slot;
      end
      if (cmd.op == DO_PFIN) begin
        seed_index <= cur;
      end
    end
  end

  always_ff @(posedge clk) begin
    unique case (cmd.op)
      DO_CAPTURE: begin
        if (s_tuser == OP_QUERY) begin
          dx <= s_tdata[31:0];
          dy <= s_tdata[63:32];
          dz <= s_tdata[95:64];
          px <= '0;
          py <= '0;
          pz <= '0;
          chosen <= '0;
          err <= 1'b0;
        end
      end
      DO_BOX: begin
        px <= ($signed(dx) < -32'sd1) ? 32'(-{1'b0, half_x}) : {1'b0, half_x};
        py <= ($signed(dy) < -32'sd1) ? 32'(-{1'b0, half_y}) : {1'b0, half_y};
        pz <= ($signed(dz) < -32'sd1) ? 32'(-{1'b0, half_z}) : {1'b0, half_z};
      end
      DO_SQY: sqxy <= prod;
      DO_SQZ: sqxy <= sqxy + prod;
      DO_SQA: sqall <= sqxy + prod;
      DO_PL: pl <= sq_root;
      DO_LEN: begin
        len <= sq_root;
        radius_cur <= radius_main;
        if (shape_kind == KIND_CYL) begin
          pz <= ($signed(dz) < -32'sd1) ? neg_hh : {1'b0, half_height};
        end
      end
      DO_CONE_SEL: begin
        radius_cur <= bottom ? radius_bottom : radius_main;
        pz <= bottom ? neg_hh : {1'b0, half_height};
      end
      DO_DWRITE: begin
        unique case (cmd.axis)
          2'd0: px <= dx[31] ? 32'(-dv_q) : dv_q;
          2'd1: py <= dy[31] ? 32'(-dv_q) : dv_q;
          default: pz <= dz[31] ? 32'(-dv_q) : dv_q;
        endcase
      end
      DO_EMPTY: err <= 1'b1;
      DO_CINIT: begin
        cur <= seed_sel;
        didx <= seed_sel;
      end
      DO_DMY: acc <= prod_fl[DOT_W-1:0];
      DO_DMZ: acc <= acc + prod_fl[DOT_W-1:0];
      DO_DACC: ndp <= acc + prod_fl[DOT_W-1:0];
      DO_FIRST: begin
        dp <= ndp;
        nxt <= vinc(cur, vertex_count);
        didx <= vinc(cur, vertex_count);
      end
      DO_SECOND: begin
        if (gt) begin
          dir_back <= 1'b0;
          dp <= ndp;
          cur <= nxt;
          nxt <= vinc(nxt, vertex_count);
          didx <= vinc(nxt, vertex_count);
          steps <= 7'd1;
        end else begin
          dir_back <= 1'b1;
          nxt <= vdec(cur, vertex_count);
          didx <= vdec(cur, vertex_count);
          steps <= '0;
        end
      end
      DO_STEP: begin
        dp <= ndp;
        cur <= nxt;
        nxt <= dir_back ? vdec(nxt, vertex_count) : vinc(nxt, vertex_count);
        didx <= dir_back ? vdec(nxt, vertex_count) : vinc(nxt, vertex_count);
        steps <= steps + 7'd1;
      end
      DO_PFIN: begin
        chosen <= cur;
        didx <= cur;
      end
      DO_PLOAD: begin
        px <= rdata[31:0];
        py <= rdata[63:32];
        pz <= rdata[95:64];
      end
      DO_OUT: begin
        ox <= px;
        oy <= py;
        oz <= pz;
        ochosen <= chosen;
        oerr <= err;
      end
      default: ;
    endcase
  end

  cspu_ram #(
    .WIDTH(96),
    .DEPTH(VTX_DEPTH)
  ) u_vtx (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot),
    .wdata(s_tdata[95:0]),
    .raddr(didx),
    .rdata(rdata)
  );

  cspu_sqrt u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .start   (sq_start),
    .radicand(sq_in),
    .busy    (sq_busy),
    .done    (sq_done),
    .root    (sq_root)
  );

  cspu_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (dv_start),
    .dividend(prod),
    .divisor (dv_dsr),
    .busy    (dv_busy),
    .done    (dv_done),
    .quotient(dv_q)
  );

  assign m_tdata = {2'b00, ochosen, oz, oy, ox};
  assign m_tuser = oerr;

  always_comb begin
    status.kind = shape_kind;
    status.count_zero = (vertex_count == '0);
    status.scale_ok = (shape_kind == KIND_SPHERE) ? (len > 32'd1) : (pl > 32'd1);
    status.last_axis = (shape_kind == KIND_SPHERE) ? 2'd2 : 2'd1;
    status.sqrt_done = sq_done;
    status.div_done = dv_done;
    status.sqrt_busy = sq_busy;
    status.div_busy = dv_busy;
    status.climb_cont = cont;
  end

endmodule

[design/cspu_ctrl.sv]
// controller state machine: sequences each request through the datapath
// depends on cspu_pkg
module cspu_ctrl
  import cspu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,
  output logic         m_tvalid,
  input  logic         m_tready,
  input  cspu_status_t status,
  output cspu_cmd_t    cmd
);

  localparam logic [4:0] S_IDLE = 5'd0;
  localparam logic [4:0] S_BOX = 5'd1;
  localparam logic [4:0] S_SQX = 5'd2;
  localparam logic [4:0] S_SQY = 5'd3;
  localparam logic [4:0] S_SQZ = 5'd4;
  localparam logic [4:0] S_SQA = 5'd5;
  localparam logic [4:0] S_SQ1 = 5'd6;
  localparam logic [4:0] S_SQ2 = 5'd7;
  localparam logic [4:0] S_CMUL = 5'd8;
  localparam logic [4:0] S_CSEL = 5'd9;
  localparam logic [4:0] S_CHK = 5'd10;
  localparam logic [4:0] S_SMUL = 5'd11;
  localparam logic [4:0] S_DST = 5'd12;
  localparam logic [4:0] S_DWT = 5'd13;
  localparam logic [4:0] S_CINIT = 5'd14;
  localparam logic [4:0] S_DRD = 5'd15;
  localparam logic [4:0] S_DMX = 5'd16;
  localparam logic [4:0] S_DMY = 5'd17;
  localparam logic [4:0] S_DMZ = 5'd18;
  localparam logic [4:0] S_DACC = 5'd19;
  localparam logic [4:0] S_FIRST = 5'd20;
  localparam logic [4:0] S_SECOND = 5'd21;
  localparam logic [4:0] S_LOOP = 5'd22;
  localparam logic [4:0] S_PRD = 5'd23;
  localparam logic [4:0] S_PLD = 5'd24;
  localparam logic [4:0] S_DONE = 5'd25;

  localparam logic [1:0] R_FIRST = 2'd0;
  localparam logic [1:0] R_SECOND = 2'd1;
  localparam logic [1:0] R_LOOP = 2'd2;

  logic [4:0] state, state_next;
  logic [1:0] ret, ret_next;
  logic [1:0] axis, axis_next;
  logic       m_tvalid_next;
  logic       accept;
  logic       out_free;

  assign s_tready = (state == S_IDLE);
  assign accept = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;

  always_comb begin
    state_next = state;
    ret_next = ret;
    axis_next = axis;
    cmd.op = DO_NONE;
    cmd.axis = axis;
    m_tvalid_next = m_tvalid && !m_tready;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd.op = DO_CAPTURE;
          if (s_tuser == OP_QUERY) begin
            priority case (status.kind)
              KIND_BOX: state_next = S_BOX;
              KIND_SPHERE, KIND_CYL, KIND_CONE: state_next = S_SQX;
              KIND_POLY: state_next = S_CINIT;
              default: state_next = S_DONE;
            endcase
          end
        end
      end
      S_BOX: begin
        cmd.op = DO_BOX;
        state_next = S_DONE;
      end
      S_SQX: begin
        cmd.op = DO_SQX;
        state_next = S_SQY;
      end
      S_SQY: begin
        cmd.op = DO_SQY;
        state_next = S_SQZ;
      end
      S_SQZ: begin
        cmd.op = DO_SQZ;
        state_next = S_SQA;
      end
      S_SQA: begin
        cmd.op = DO_SQA;
        state_next = S_SQ1;
      end
      S_SQ1: begin
        if (status.sqrt_done) begin
          cmd.op = DO_PL;
          state_next = S_SQ2;
        end
      end
      S_SQ2: begin
        if (status.sqrt_done) begin
          cmd.op = DO_LEN;
          state_next = (status.kind == KIND_CONE) ? S_CMUL : S_CHK;
        end
      end
      S_CMUL: begin
        cmd.op = DO_CONE_MUL;
        state_next = S_CSEL;
      end
      S_CSEL: begin
        cmd.op = DO_CONE_SEL;
        state_next = S_CHK;
      end
      S_CHK: begin
        axis_next = 2'd0;
        state_next = status.scale_ok ? S_SMUL : S_DONE;
      end
      S_SMUL: begin
        cmd.op = DO_SMUL;
        state_next = S_DST;
      end
      S_DST: begin
        cmd.op = DO_DSTART;
        state_next = S_DWT;
      end
      S_DWT: begin
        if (status.div_done) begin
          cmd.op = DO_DWRITE;
          if (axis == status.last_axis) begin
            state_next = S_DONE;
          end else begin
            axis_next = axis + 2'd1;
            state_next = S_SMUL;
          end
        end
      end
      S_CINIT: begin
        if (status.count_zero) begin
          cmd.op = DO_EMPTY;
          state_next = S_DONE;
        end else begin
          cmd.op = DO_CINIT;
          ret_next = R_FIRST;
          state_next = S_DRD;
        end
      end
      // dot product of the vertex at the datapath read index
      S_DRD: state_next = S_DMX;
      S_DMX: begin
        cmd.op = DO_DMX;
        state_next = S_DMY;
      end
      S_DMY: begin
        cmd.op = DO_DMY;
        state_next = S_DMZ;
      end
      S_DMZ: begin
        cmd.op = DO_DMZ;
        state_next = S_DACC;
      end
      S_DACC: begin
        cmd.op = DO_DACC;
        unique case (ret)
          R_FIRST: state_next = S_FIRST;
          R_SECOND: state_next = S_SECOND;
          default: state_next = S_LOOP;
        endcase
      end
      S_FIRST: begin
        cmd.op = DO_FIRST;
        ret_next = R_SECOND;
        state_next = S_DRD;
      end
      S_SECOND: begin
        cmd.op = DO_SECOND;
        ret_next = R_LOOP;
        state_next = S_DRD;
      end
      S_LOOP: begin
        if (status.climb_cont) begin
          cmd.op = DO_STEP;
          state_next = S_DRD;
        end else begin
          cmd.op = DO_PFIN;
          state_next = S_PRD;
        end
      end
      S_PRD: state_next = S_PLD;
      S_PLD: begin
        cmd.op = DO_PLOAD;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) begin
          cmd.op = DO_OUT;
          m_tvalid_next = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret <= R_FIRST;
      axis <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state <= state_next;
      ret <= ret_next;
      axis <= axis_next;
      m_tvalid <= m_tvalid_next;
    end
  end

`ifndef SYNTHESIS
  a_sqrt_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DO_SQA || cmd.op == DO_PL) |-> !status.sqrt_busy)
    else $error("sqrt started while busy");
  a_div_free: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DO_DSTART) |-> !status.div_busy)
    else $error("divider started while busy");
  a_query_blocks: assert property (@(posedge clk) disable iff (rst)
    (accept && s_tuser == OP_QUERY) |=> !s_tready)
    else $error("query accepted without leaving idle");
  a_out_slot: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == DO_OUT) |-> out_free)
    else $error("result overwritten before taken");
`endif

endmodule

[design/convex_support_point_unit_top.sv]
// Support point unit for GJK. Request stream on s_*: s_tuser is the opcode
// (query, load vertex, set seed), s_tdata carries coordinates and slot,
// s_tlast marks the last vertex of a polygon load. Results leave on m_*,
// one per query; m_tuser is the empty-polygon error flag.
// Loads and seed writes are captured without leaving the idle state.
// Sphere, cylinder and cone queries use the shared multiplier and run two
// square roots and, when the direction is long enough, three (sphere) or two
// (cylinder, cone) divisions. A polygon query runs a ram read, three multiplies,
// an accumulate and a compare for each vertex examined by the climb.
// One request is worked on at a time; the finished result sits in an output
// register, so the next request is accepted while it waits. A query that
// finishes while m_tvalid is still held waits until the result is taken.
// Reset clears config, vertex count and seed; the vertex ram is not cleared.
// Config is written through cfg_we/cfg_index/cfg_data with no wait.
// depends on cspu_pkg, cspu_ctrl, cspu_datapath
module convex_support_point_unit_top
  import cspu_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         cfg_we,
  input  logic [2:0]   cfg_index,
  input  logic [30:0]  cfg_data,
  input  logic         s_tvalid,
  output logic         s_tready,
  // coord_x, coord_y, coord_z, slot_index, zero pad
  input  logic [103:0] s_tdata,
  // opcode
  input  logic [1:0]   s_tuser,
  // last_vertex
  input  logic         s_tlast,
  output logic         m_tvalid,
  input  logic         m_tready,
  // support_x, support_y, support_z, chosen_vertex, zero pad
  output logic [103:0] m_tdata,
  // status
  output logic         m_tuser
);

  cspu_cmd_t    cmd;
  cspu_status_t status;

  cspu_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tuser (s_tuser),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .status  (status),
    .cmd     (cmd)
  );

  cspu_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

[tb/tb_top.sv]
// self-checking testbench for convex_support_point_unit_top
// scoreboard class predicts each query's support point; depends on cspu_pkg
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cspu_pkg::*;

  typedef struct {
    logic [31:0] sx, sy, sz;
    logic [5:0]  vtx;
    logic        err;
  } support_t;

  class support_scoreboard;
    logic [2:0] kind;
    logic [30:0] rmain, rbot, hh, hx, hy, hz;
    logic signed [17:0] slope;
    logic signed [31:0] vx[64], vy[64], vz[64];
    int unsigned count, seed;
    support_t pending[$];
    int errors;

    function void reset_state();
      kind = KIND_BOX; rmain = 0; rbot = 0; hh = 0; hx = 0; hy = 0; hz = 0;
      slope = 0; count = 0; seed = 0; errors = 0;
      foreach (vx[i]) begin vx[i] = 0; vy[i] = 0; vz[i] = 0; end
    endfunction

    function void write_reg(logic [2:0] idx, logic [30:0] v);
      case (idx)
        REG_KIND: kind = v[2:0];
        REG_RMAIN: rmain = v;
        REG_RBOT: rbot = v;
        REG_HH: hh = v;
        REG_SLOPE: slope = v[17:0];
        REG_HX: hx = v;
        REG_HY: hy = v;
        default: hz = v;
      endcase
    endfunction

    function longint unsigned root(longint unsigned v);
      longint unsigned r, b;
      r = 0; b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
        if (v >= r + b) begin v -= r + b; r = (r >> 1) + b; end
        else r >>= 1;
        b >>= 2;
      end
      return r;
    endfunction

    function longint fshr(longint p);
      return p >>> FRAC_BITS;  // arithmetic shift is floor
    endfunction

    function longint scaled(longint d, longint unsigned r, longint unsigned l);
      longint unsigned q, m;
      m = d < 0 ? -d : d;
      q = m * r / l;
      return d < 0 ? -longint'(q) : longint'(q);
    endfunction

    function longint dot(int unsigned i, longint d[3]);
      return fshr(vx[i] * d[0]) + fshr(vy[i] * d[1]) + fshr(vz[i] * d[2]);
    endfunction

    function int unsigned hill_climb(longint d[3]);
      int unsigned cur, nxt, steps;
      longint dp, ndp;
      cur = seed >= count ? 0 : seed;
      dp = dot(cur, d);
      nxt = cur + 1 < count ? cur + 1 : 0;
      ndp = dot(nxt, d);
      steps = 0;
      if (ndp > dp) begin
        do begin
          dp = ndp; cur = nxt;
          nxt = nxt + 1 < count ? nxt + 1 : 0;
          ndp = dot(nxt, d);
          steps++;
        end while (ndp > dp + 1 && steps < count);
      end else begin
        nxt = cur == 0 ? count - 1 : cur - 1;
        ndp = dot(nxt, d);
        while (ndp > dp + 1 && steps < count) begin
          dp = ndp; cur = nxt;
          nxt = nxt == 0 ? count - 1 : nxt - 1;
          ndp = dot(nxt, d);
          steps++;
        end
      end
      return cur;
    endfunction

    function void note_request(logic [1:0] op, logic [103:0] data, logic lastv);
      longint d[3], p[3], rhs;
      longint unsigned sqxy, pl, len, r;
      int unsigned slot, ch;
      support_t s;
      bit bottom;
      d[0] = $signed(data[31:0]); d[1] = $signed(data[63:32]);
      d[2] = $signed(data[95:64]);
      slot = data[101:96];
      if (op == OP_LOAD) begin
        vx[slot] = d[0]; vy[slot] = d[1]; vz[slot] = d[2];
        if (lastv) count = slot + 1;
        return;
      end
      if (op == OP_SEED) begin seed = slot; return; end
      if (op != OP_QUERY) return;
      p[0] = 0; p[1] = 0; p[2] = 0; ch = 0; s.err = 0;
      sqxy = d[0] * d[0] + d[1] * d[1];
      pl = root(sqxy);
      len = root(sqxy + d[2] * d[2]);
      case (kind)
        KIND_BOX: begin
          p[0] = d[0] < -1 ? -longint'(hx) : hx;
          p[1] = d[1] < -1 ? -longint'(hy) : hy;
          p[2] = d[2] < -1 ? -longint'(hz) : hz;
        end
        KIND_SPHERE:
          if (len > 1) for (int i = 0; i < 3; i++) p[i] = scaled(d[i], rmain, len);
        KIND_CYL: begin
          if (pl > 1) begin
            p[0] = scaled(d[0], rmain, pl); p[1] = scaled(d[1], rmain, pl);
          end
          p[2] = d[2] < -1 ? -longint'(hh) : hh;
        end
        KIND_CONE: begin
          rhs = fshr(longint'(len) * slope);
          bottom = d[2] <= rhs + 1;
          r = bottom ? rbot : rmain;
          if (pl > 1) begin
            p[0] = scaled(d[0], r, pl); p[1] = scaled(d[1], r, pl);
          end
          p[2] = bottom ? -longint'(hh) : hh;
        end
        KIND_POLY:
          if (count == 0) s.err = 1;
          else begin
            ch = hill_climb(d);
            seed = ch;
            p[0] = vx[ch]; p[1] = vy[ch]; p[2] = vz[ch];
          end
        default: ;
      endcase
      s.sx = p[0][31:0]; s.sy = p[1][31:0]; s.sz = p[2][31:0];
      s.vtx = ch[5:0];
      pending.push_back(s);
    endfunction

    function void mismatch(string what, logic [31:0] got, logic [31:0] want);
      $display("mismatch %s: got %h expected %h at %0t", what, got, want, $realtime);
      errors++;
    endfunction

    function void check_result(logic [103:0] data, logic err);
      support_t s;
      if (pending.size() == 0) begin
        mismatch("unexpected result", data[31:0], 0);
        return;
      end
      s = pending.pop_front();
      if (data[31:0] !== s.sx) mismatch("support_x", data[31:0], s.sx);
      if (data[63:32] !== s.sy) mismatch("support_y", data[63:32], s.sy);
      if (data[95:64] !== s.sz) mismatch("support_z", data[95:64], s.sz);
      if (data[101:96] !== s.vtx) mismatch("chosen_vertex", data[101:96], s.vtx);
      if (data[103:102] !== 2'b00) mismatch("pad", data[103:102], 0);
      if (m_err_x(err) !== s.err) mismatch("status", err, s.err);
    endfunction

    function logic m_err_x(logic e);
      return e;
    endfunction
  endclass

  logic clk, rst, cfg_we, s_tvalid, s_tready, s_tlast, m_tvalid, m_tready, m_tuser;
  logic [2:0] cfg_index;
  logic [30:0] cfg_data;
  logic [103:0] s_tdata, m_tdata;
  logic [1:0] s_tuser;

  support_scoreboard sb;
  int unsigned cycles, queries, loads;
  int unsigned stall_left = 0;
  bit idle_on;

  convex_support_point_unit_top uut (.*);

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("timeout");
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // receiver: random stall bursts, sampled at the edge
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      m_tready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 3) == 0) begin
      stall_left <= $urandom_range(0, 3);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  task automatic write_cfg(logic [2:0] idx, logic [30:0] v);
    s_tvalid <= 0;
    cfg_we <= 1; cfg_index <= idx; cfg_data <= v;
    @(posedge clk);
    cfg_we <= 0;
    @(posedge clk);
    sb.write_reg(idx, v);
  endtask

  task automatic wait_drained();
    s_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  // leaves s_tvalid high; the next task call in the same step drives it
  task automatic send(logic [1:0] op, logic [31:0] x, logic [31:0] y, logic [31:0] z,
                      logic [5:0] slot, logic lastv);
    int gap;
    if (idle_on && $urandom_range(0, 4) == 0) begin
      gap = $urandom_range(1, 4);
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1; s_tuser <= op; s_tlast <= lastv;
    s_tdata <= {2'b00, slot, z, y, x};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    sb.note_request(op, {2'b00, slot, z, y, x}, lastv);
    if (op == OP_QUERY) queries++;
    if (op == OP_LOAD) loads++;
  endtask

  function automatic logic [31:0] rnd_coord();
    case ($urandom_range(0, 4))
      0: return $urandom();
      1: return $urandom_range(0, 3) - 2;  // near zero
      2: return {$urandom_range(0, 1) ? 16'hffff : 16'h0000, 16'($urandom())};
      default: return 32'($signed($urandom_range(0, 32'h00ffffff)) - 32'sh00800000);
    endcase
  endfunction

  task automatic rnd_query();
    send(OP_QUERY, rnd_coord(), rnd_coord(), rnd_coord(), 6'($urandom()),
         1'($urandom()));
  endtask

  task automatic load_polygon(int unsigned n, bit full_range);
    for (int i = 0; i < n; i++)
      send(OP_LOAD, full_range ? $urandom() : rnd_coord(),
           full_range ? $urandom() : rnd_coord(), rnd_coord(), 6'(i), i == n - 1);
  endtask

  task automatic rnd_shape_cfg(logic [2:0] kind, bit extreme);
    write_cfg(REG_KIND, 31'(kind));
    for (int r = 1; r < 8; r++) begin
      if (r == REG_SLOPE) write_cfg(REG_SLOPE, extreme ? ($urandom_range(0, 1) ?
        31'h0001_0000 : 31'h0003_0000) : 31'($urandom_range(0, 18'h3ffff)));
      else write_cfg(r[2:0], extreme ? ($urandom_range(0, 1) ? 31'h7fffffff : 31'd0)
                                   : ($urandom_range(0, 1) ? 31'($urandom()) :
                                      31'($urandom_range(0, 32'h00ffffff))));
    end
  endtask

  initial begin
    sb = new();
    sb.reset_state();
    rst = 1; cfg_we = 0; cfg_index = 0; cfg_data = 0;
    s_tvalid = 0; s_tdata = 0; s_tuser = 0; s_tlast = 0; m_tready = 1;
    cycles = 0; queries = 0; loads = 0; idle_on = 1;
    repeat (12) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: empty polygon, unknown opcode, extreme directions
    write_cfg(REG_KIND, 31'(KIND_POLY));
    send(OP_QUERY, 32'h10000, 0, 0, 0, 0);
    send(2'd3, 32'hffffffff, 32'hffffffff, 32'hffffffff, 6'h3f, 1);
    wait_drained();
    for (int k = 0; k < 4; k++) begin
      rnd_shape_cfg(k[2:0], 1);
      send(OP_QUERY, 32'h80000000, 32'h7fffffff, 32'hffffffff, 6'h3f, 1);
      send(OP_QUERY, 0, 0, 0, 0, 0);
      send(OP_QUERY, 32'hfffffffe, 1, 32'hfffffffe, 0, 0);
      send(OP_QUERY, 32'h7fffffff, 32'h80000000, 32'h7fffffff, 0, 0);
      wait_drained();
    end
    write_cfg(REG_KIND, 31'd5);  // unknown shape
    send(OP_QUERY, 32'h1234, 32'h5678, 32'h9abc, 0, 0);
    wait_drained();
    write_cfg(REG_KIND, 31'(KIND_POLY));
    load_polygon(64, 1);
    send(OP_SEED, 0, 0, 0, 6'h3f, 0);
    send(OP_QUERY, 32'h80000000, 32'h80000000, 32'h80000000, 0, 0);
    send(OP_SEED, 0, 0, 0, 6'd0, 0);
    send(OP_QUERY, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 0, 0);
    wait_drained();

    // random phases over all shapes
    for (int ph = 0; ph < 24; ph++) begin
      int unsigned kind;
      if (ph >= 20) idle_on = 0;
      kind = ph % 6 == 5 ? $urandom_range(5, 7) : ph % 6 == 4 ? KIND_POLY : ph % 5;
      rnd_shape_cfg(kind[2:0], ph % 7 == 6);
      if (kind == KIND_POLY) begin
        for (int g = 0; g < 4; g++) begin
          int unsigned n;
          n = $urandom_range(0, 3) == 0 ? 64 : $urandom_range(3, 12);
          load_polygon(n, 1'($urandom_range(0, 1)));
          for (int q = 0; q < 12; q++) begin
            if ($urandom_range(0, 5) == 0) send(OP_SEED, 0, 0, 0, 6'($urandom()), 0);
            else rnd_query();
          end
        end
      end else
        for (int q = 0; q < 25; q++) rnd_query();
      wait_drained();
    end

    $display("covered %0d queries and %0d vertex loads over all shape kinds,",
             queries, loads);
    $display("with empty and full polygons, seed moves and extreme registers");
    if (sb.errors == 0 && sb.pending.size() == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end
endmodule
